@@ hdl/sfas_pkg.sv @@
// Shared types and constants for the screen fade alpha sequencer.
`timescale 1ns / 1ps

package sfas_pkg;

  // Widths fixed by the command and result fields
  localparam int LEN_W      = 16;
  localparam int DELAY_W    = 16;
  localparam int ALPHA_W    = 8;
  localparam int TIME_BITS_DEF = 16;

  localparam logic [ALPHA_W-1:0] FULL_ALPHA = 8'hFF;

  typedef enum logic [1:0] {
    ST_OPAQUE   = 2'd0,
    ST_CLEAR    = 2'd1,
    ST_FADE_IN  = 2'd2,
    ST_FADE_OUT = 2'd3
  } fade_state_t;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_FADE_IN  = 2'd1,
    OP_FADE_OUT = 2'd2,
    OP_SET      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_DONE
  } seq_state_t;

endpackage

@@ hdl/sfas_div.sv @@
// Iterative divider: quotient of step*255 by total, one quotient bit per cycle.
`timescale 1ns / 1ps

module sfas_div #(
  parameter int TW = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [TW-1:0]             step,
  input  logic [TW-1:0]             total,
  output logic                      done,
  output logic [sfas_pkg::ALPHA_W-1:0] quot
);
  import sfas_pkg::*;

  // step <= total, so the quotient fits in ALPHA_W bits and the upper
  // part of the dividend starts below total.
  logic [TW+ALPHA_W-1:0] dividend;
  logic [TW-1:0]         rem_r, rem_nxt;
  logic [TW-1:0]         total_r;
  logic [ALPHA_W-1:0]    low_r, low_nxt;
  logic [2:0]            cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [TW:0]           trial;
  logic [TW:0]           diff;
  logic                  ge;

  assign dividend = {step, {ALPHA_W{1'b0}}} - {{ALPHA_W{1'b0}}, step};

  assign trial = {rem_r, low_r[ALPHA_W-1]};
  assign ge    = (trial >= {1'b0, total_r});
  assign diff  = trial - {1'b0, total_r};

  always_comb begin
    rem_nxt = ge ? diff[TW-1:0] : trial[TW-1:0];
    low_nxt = {low_r[ALPHA_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load on start, shift-subtract while busy
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= dividend[TW+ALPHA_W-1:ALPHA_W];
      low_r   <= dividend[ALPHA_W-1:0];
      total_r <= total;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end
  end

  assign done = done_r;
  assign quot = low_r;

endmodule

@@ hdl/screen_fade_alpha_sequencer.sv @@
// Top level of the screen fade alpha sequencer: command decode, fade state and result register.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_*): one command beat each - tick, start fade in,
//   start fade out, or set status with an optional delay in ticks.
//   Result channel (out_*): exactly one result beat per command, carrying
//   alpha, fade state, accepted flag and draw enable, in command order.
//   Both channels use valid/stall; a beat moves when valid is high and
//   stall is low.
// Command flow
//   A tick during an active fade runs the shift-subtract divider for
//   step*255/length, one quotient bit per cycle, and passes through the
//   divide state and then the done state to the result register. Every
//   other command goes through the done state only. in_stall is high
//   while a command is in flight, so a new command is taken only after
//   the last one has left the done state.
// Stall behavior
//   The result register holds its beat while out_stall is high. The next
//   command may be accepted and worked on meanwhile; its result waits in
//   the done state until the register frees up.
// Reset
//   Synchronous, active low: state opaque, alpha 255, no pending status
//   change, fade step and length zero, result register empty.

module screen_fade_alpha_sequencer #(
  parameter int TIME_BITS = sfas_pkg::TIME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [sfas_pkg::LEN_W-1:0]   in_fade_length,
  input  logic [1:0]                 in_target_state,
  input  logic [sfas_pkg::DELAY_W-1:0] in_delay_ticks,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sfas_pkg::ALPHA_W-1:0] out_alpha,
  output logic [1:0]                 out_fade_state,
  output logic                       out_accepted,
  output logic                       out_draw_enable
);
  import sfas_pkg::*;

  // Fade length is masked to TIME_BITS and can never exceed the field width
  localparam int TW = (TIME_BITS < LEN_W) ? TIME_BITS : LEN_W;

  seq_state_t          seq_r, seq_nxt;
  fade_state_t         fade_state_r, fade_state_nxt;
  fade_state_t         pending_r, pending_nxt;
  logic                armed_r, armed_nxt;
  logic [DELAY_W-1:0]  cnt_r, cnt_nxt;
  logic [TW-1:0]       step_r, step_nxt;
  logic [TW-1:0]       total_r, total_nxt;
  logic [ALPHA_W-1:0]  alpha_r, alpha_nxt;
  logic                acc_r, acc_nxt;
  logic                dir_in_r, dir_in_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ALPHA_W-1:0]  out_alpha_r;
  fade_state_t         out_state_r;
  logic                out_acc_r;
  logic                out_draw_r;

  logic                in_take;
  logic                need_div;
  logic                div_start;
  logic                div_done;
  logic [ALPHA_W-1:0]  div_q;
  logic [TW-1:0]       step_inc;
  logic                out_load;

  assign in_take  = in_valid && !in_stall;
  assign step_inc = step_r + TW'(1);

  // Command decode and fade state update
  always_comb begin
    fade_state_t st;
    fade_state_t need;
    fade_state_nxt = fade_state_r;
    pending_nxt    = pending_r;
    armed_nxt      = armed_r;
    cnt_nxt        = cnt_r;
    step_nxt       = step_r;
    total_nxt      = total_r;
    alpha_nxt      = alpha_r;
    acc_nxt        = acc_r;
    dir_in_nxt     = dir_in_r;
    need_div       = 1'b0;
    st             = fade_state_r;
    need           = ST_OPAQUE;
    if (in_take) begin
      acc_nxt = 1'b1;
      unique case (opcode_t'(in_opcode))
        OP_TICK: begin
          // Delayed status lands when the countdown has reached zero
          if (armed_r) begin
            if (cnt_r == '0) begin
              st        = pending_r;
              armed_nxt = 1'b0;
            end else begin
              cnt_nxt = cnt_r - DELAY_W'(1);
            end
          end
          unique case (st)
            ST_OPAQUE: alpha_nxt = FULL_ALPHA;
            ST_CLEAR:  ;
            ST_FADE_IN, ST_FADE_OUT: begin
              if (total_r == '0) begin
                // Zero length fade: finish at once
                alpha_nxt = (st == ST_FADE_IN) ? '0 : FULL_ALPHA;
                st        = (st == ST_FADE_IN) ? ST_CLEAR : ST_OPAQUE;
              end else begin
                step_nxt   = step_inc;
                need_div   = 1'b1;
                dir_in_nxt = (st == ST_FADE_IN);
                if (step_inc >= total_r) begin
                  st = (st == ST_FADE_IN) ? ST_CLEAR : ST_OPAQUE;
                end
              end
            end
            default: ;
          endcase
          fade_state_nxt = st;
        end
        OP_FADE_IN, OP_FADE_OUT: begin
          need = (opcode_t'(in_opcode) == OP_FADE_IN) ? ST_OPAQUE : ST_CLEAR;
          if (fade_state_r == need) begin
            fade_state_nxt = (opcode_t'(in_opcode) == OP_FADE_IN) ? ST_FADE_IN : ST_FADE_OUT;
            step_nxt       = '0;
            total_nxt      = in_fade_length[TW-1:0];
          end else begin
            acc_nxt = 1'b0;
          end
        end
        OP_SET: begin
          // Targets other than opaque and clear are dropped
          if (in_target_state == 2'(ST_OPAQUE) || in_target_state == 2'(ST_CLEAR)) begin
            pending_nxt = fade_state_t'(in_target_state);
            armed_nxt   = 1'b1;
            if (in_delay_ticks != '0) begin
              cnt_nxt = in_delay_ticks;
            end else begin
              fade_state_nxt = fade_state_t'(in_target_state);
              cnt_nxt        = '0;
            end
          end
        end
        default: ;
      endcase
    end
    // Divider result becomes the new alpha
    if (div_done) begin
      alpha_nxt = dir_in_r ? (FULL_ALPHA - div_q) : div_q;
    end
  end

  // Sequencer next state
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      SEQ_IDLE: if (in_take) seq_nxt = need_div ? SEQ_DIV : SEQ_DONE;
      SEQ_DIV:  if (div_done) seq_nxt = SEQ_DONE;
      SEQ_DONE: if (!out_valid_r || !out_stall) seq_nxt = SEQ_IDLE;
      default:  seq_nxt = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall  = (seq_r != SEQ_IDLE);
    div_start = in_take && need_div;
    out_load  = (seq_r == SEQ_DONE) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  sfas_div #(
    .TW (TW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .step  (step_inc),
    .total (total_r),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r        <= SEQ_IDLE;
      fade_state_r <= ST_OPAQUE;
      pending_r    <= ST_OPAQUE;
      armed_r      <= 1'b0;
      cnt_r        <= '0;
      step_r       <= '0;
      total_r      <= '0;
      alpha_r      <= FULL_ALPHA;
      acc_r        <= 1'b1;
      dir_in_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      seq_r        <= seq_nxt;
      fade_state_r <= fade_state_nxt;
      pending_r    <= pending_nxt;
      armed_r      <= armed_nxt;
      cnt_r        <= cnt_nxt;
      step_r       <= step_nxt;
      total_r      <= total_nxt;
      alpha_r      <= alpha_nxt;
      acc_r        <= acc_nxt;
      dir_in_r     <= dir_in_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload: capture committed state on load, hold otherwise
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_alpha_r <= alpha_r;
      out_state_r <= fade_state_r;
      out_acc_r   <= acc_r;
      out_draw_r  <= (alpha_r != '0) && (fade_state_r != ST_CLEAR);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_alpha       = out_alpha_r;
  assign out_fade_state  = out_state_r;
  assign out_accepted    = out_acc_r;
  assign out_draw_enable = out_draw_r;

  // The divider only reports back while a tick waits on it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> seq_r == SEQ_DIV)
    else $error("divider done outside divide state");

  // A freed result register is filled on the next edge
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result load lost");

  // The fade never steps beyond its length
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fade_state_r == ST_FADE_IN || fade_state_r == ST_FADE_OUT) |-> step_r <= total_r)
    else $error("fade step beyond length");

  // Draw enable implies a visible, non-clear overlay
  a_draw_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_draw_r) |-> (out_alpha_r != '0 && out_state_r != ST_CLEAR))
    else $error("draw enable inconsistent with alpha or state");

endmodule
